### rtl/srr_pkg.sv
// Shared constants, types and helpers for the selective-repeat receiver.
// Used by srr_csum_unit and selective_repeat_receiver; depends on nothing.
package srr_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int MAX_RUN      = 32;
  localparam int SLOT_W       = $clog2(BUFFER_DEPTH);
  localparam int SEQ_W        = 31;
  localparam int WORD_W       = 32;
  localparam int WIN_W        = 6;
  localparam int RUN_W        = $clog2(MAX_RUN + 1);
  localparam int PAYLOAD_W    = 160;
  localparam int GROUP_W      = 32;
  localparam int GROUPS       = PAYLOAD_W / GROUP_W;
  localparam int GROUP_CNT_W  = $clog2(GROUPS);
  localparam int GROUP_BYTES  = GROUP_W / 8;
  localparam int WIN_MAX      = (BUFFER_DEPTH < MAX_RUN) ? BUFFER_DEPTH : MAX_RUN;

  localparam int IN_TDATA_W   = 256;
  localparam int OUT_TDATA_W  = 224;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  // register index decoded from paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(8);
  localparam logic [SEQ_W-1:0]  BASE_RESET   = SEQ_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_RESET   = SLOT_W'(1 % BUFFER_DEPTH);
  // slot offset lost when the base wraps past 2^31
  localparam logic [SLOT_W-1:0] WRAP_SLOT    = SLOT_W'((64'd1 << SEQ_W) % BUFFER_DEPTH);

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic                   load;
    logic                   step;
    logic [GROUP_CNT_W-1:0] group;
  } csum_ctrl_t;

  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    if (int'(w) > WIN_MAX) return WIN_W'(WIN_MAX);
    return w;
  endfunction

endpackage

### rtl/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/srr_csum_unit.sv
// Checksum accumulator: adds one 32-bit group of signed payload bytes per step.
// Depends on srr_pkg.
module srr_csum_unit (
  input  logic                           clk_i,
  input  srr_pkg::csum_ctrl_t            ctrl_i,
  input  logic [srr_pkg::WORD_W-1:0]     init_i,
  input  logic [srr_pkg::PAYLOAD_W-1:0]  payload_i,
  output logic [srr_pkg::WORD_W-1:0]     sum_o
);

  logic [srr_pkg::WORD_W-1:0]  acc_q;
  logic [srr_pkg::GROUP_W-1:0] group_word;
  logic [srr_pkg::WORD_W-1:0]  group_sum;

  assign group_word = payload_i[ctrl_i.group * srr_pkg::GROUP_W +: srr_pkg::GROUP_W];

  always_comb begin
    logic [7:0] b;
    group_sum = '0;
    for (int i = 0; i < srr_pkg::GROUP_BYTES; i++) begin
      b = group_word[i*8 +: 8];
      group_sum = group_sum + {{(srr_pkg::WORD_W-8){b[7]}}, b};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= init_i;
    end else if (ctrl_i.step) begin
      acc_q <= acc_q + group_sum;
    end
  end

  assign sum_o = acc_q;

endmodule

### rtl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver: checksum, window check, reorder buffer, in-order delivery.
// Depends on srr_pkg, srr_csum_unit and srr_ram.
//
//  channel  | dir | handshake                  | contents
//  s_axis   | in  | tvalid/tready              | one packet word
//  m_axis   | out | tvalid/tready, tlast       | ack or delivered payload word
//  apb      | in  | psel/penable/pwrite/pready | window_size register
//
// A packet passes through accept, 5 checksum steps through the checksum
// accumulator (one 4-byte group each), window check and, if it passes, ack.
// Each delivered payload adds a reorder RAM read, then an output load.
// Output stalls hold the sequencer in its ack or delivery state.
// No clearing pass: slot flags are flip-flops cleared at reset.
module selective_repeat_receiver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // seq_number, ack_number, packet_checksum, payload_low, payload_mid, payload_high
  input  logic [srr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ack_seq, ack_check, data_low, data_mid, data_high
  output logic [srr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // result_kind
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [srr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [srr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_ACK,
    ST_READ,
    ST_EMIT
  } state_e;

  localparam int SW = srr_pkg::SLOT_W;
  localparam int D  = srr_pkg::BUFFER_DEPTH;

  state_e                           state_q;
  logic [srr_pkg::SEQ_W-1:0]        seq_q;
  logic [srr_pkg::WORD_W-1:0]       chk_q;
  logic [srr_pkg::PAYLOAD_W-1:0]    payload_q;
  logic [srr_pkg::GROUP_CNT_W-1:0]  grp_q;
  logic [srr_pkg::SEQ_W-1:0]        base_q;
  logic [SW-1:0]                    base_slot_q;
  logic [SW-1:0]                    run_slot_q;
  logic [srr_pkg::RUN_W-1:0]        run_cnt_q;
  logic [D-1:0]                     filled_q;
  logic                             at_base_q;
  logic [srr_pkg::WIN_W-1:0]        window_q;

  logic                             m_valid_q;
  logic                             m_kind_q;
  logic                             m_last_q;
  logic [srr_pkg::SEQ_W-1:0]        m_seq_q;
  logic [srr_pkg::PAYLOAD_W-1:0]    m_data_q;

  // input word unpacking
  logic [srr_pkg::SEQ_W-1:0]        in_seq;
  logic [srr_pkg::WORD_W-1:0]       in_ack;
  logic [srr_pkg::WORD_W-1:0]       in_chk;
  logic [srr_pkg::PAYLOAD_W-1:0]    in_payload;

  assign in_seq     = s_axis_tdata[30:0];
  assign in_ack     = s_axis_tdata[62:31];
  assign in_chk     = s_axis_tdata[94:63];
  assign in_payload = s_axis_tdata[254:95];

  logic accept;
  logic out_free;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // checksum unit
  srr_pkg::csum_ctrl_t        csum_ctrl;
  logic [srr_pkg::WORD_W-1:0] csum_init;
  logic [srr_pkg::WORD_W-1:0] csum_sum;

  assign csum_ctrl.load  = accept;
  assign csum_ctrl.step  = (state_q == ST_SUM);
  assign csum_ctrl.group = grp_q;
  assign csum_init       = srr_pkg::WORD_W'(in_seq) + in_ack;

  srr_csum_unit u_csum (
    .clk_i     (clk_i),
    .ctrl_i    (csum_ctrl),
    .init_i    (csum_init),
    .payload_i (payload_q),
    .sum_o     (csum_sum)
  );

  // window check and slot arithmetic
  logic [srr_pkg::WIN_W-1:0]  win;
  logic [srr_pkg::WORD_W-1:0] limit;
  logic [srr_pkg::WORD_W-1:0] seq_p1;
  logic                       in_window;
  logic                       at_or_above;
  logic                       csum_ok;
  logic                       pkt_ok;
  logic                       do_store;
  logic [SW-1:0]              diff;
  logic [SW:0]                slot_sum;
  logic [SW-1:0]              seq_slot;
  logic [SW-1:0]              next_slot;
  logic [srr_pkg::RUN_W-1:0]  run_cnt_inc;
  logic                       more;
  logic [srr_pkg::WORD_W-1:0] base_new;
  logic [SW-1:0]              wrap_slot;

  assign win         = srr_pkg::eff_window(window_q);
  assign limit       = srr_pkg::WORD_W'(base_q) + srr_pkg::WORD_W'(win);
  assign seq_p1      = srr_pkg::WORD_W'(seq_q) + srr_pkg::WORD_W'(1);
  assign in_window   = (seq_p1 <= limit);
  assign at_or_above = (seq_q >= base_q);
  assign csum_ok     = (csum_sum == chk_q);
  assign pkt_ok      = csum_ok && in_window;
  assign do_store    = (state_q == ST_CHECK) && pkt_ok && at_or_above;

  // seq - base stays below the window, so one conditional subtract wraps the slot
  assign diff     = SW'(seq_q - base_q);
  assign slot_sum = {1'b0, base_slot_q} + {1'b0, diff};
  assign seq_slot = (slot_sum >= (SW+1)'(D)) ? SW'(slot_sum - (SW+1)'(D)) : SW'(slot_sum);

  assign next_slot   = (run_slot_q == SW'(D - 1)) ? '0 : run_slot_q + SW'(1);
  assign run_cnt_inc = run_cnt_q + srr_pkg::RUN_W'(1);
  assign more        = ((srr_pkg::RUN_W+1)'(run_cnt_inc) < (srr_pkg::RUN_W+1)'(win))
                       && filled_q[next_slot];
  assign base_new    = srr_pkg::WORD_W'(base_q) + srr_pkg::WORD_W'(run_cnt_inc);
  assign wrap_slot   = (next_slot >= srr_pkg::WRAP_SLOT)
                       ? next_slot - srr_pkg::WRAP_SLOT
                       : SW'((SW+1)'(next_slot) + (SW+1)'(D) - (SW+1)'(srr_pkg::WRAP_SLOT));

  // reorder buffer
  logic [srr_pkg::PAYLOAD_W-1:0] ram_rdata;

  srr_ram #(
    .WIDTH (srr_pkg::PAYLOAD_W),
    .DEPTH (D)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (do_store),
    .waddr_i (seq_slot),
    .wdata_i (payload_q),
    .re_i    (state_q == ST_READ),
    .raddr_i (run_slot_q),
    .rdata_o (ram_rdata)
  );

  logic emit_fire;
  logic out_load;
  assign emit_fire = (state_q == ST_EMIT) && out_free;
  assign out_load  = ((state_q == ST_ACK) && out_free) || emit_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= '0;
      base_q      <= srr_pkg::BASE_RESET;
      base_slot_q <= srr_pkg::SLOT_RESET;
      run_slot_q  <= '0;
      run_cnt_q   <= '0;
      filled_q    <= '0;
      at_base_q   <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            seq_q     <= in_seq;
            chk_q     <= in_chk;
            payload_q <= in_payload;
            grp_q     <= '0;
            state_q   <= ST_SUM;
          end
        end
        ST_SUM: begin
          grp_q <= grp_q + srr_pkg::GROUP_CNT_W'(1);
          if (grp_q == srr_pkg::GROUP_CNT_W'(srr_pkg::GROUPS - 1)) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          at_base_q <= (seq_q == base_q);
          if (do_store) begin
            filled_q[seq_slot] <= 1'b1;
          end
          state_q <= pkt_ok ? ST_ACK : ST_IDLE;
        end
        ST_ACK: begin
          if (out_free) begin
            m_kind_q   <= srr_pkg::KIND_ACK;
            m_seq_q    <= seq_q;
            m_data_q   <= '0;
            m_last_q   <= !at_base_q;
            run_slot_q <= base_slot_q;
            run_cnt_q  <= '0;
            state_q    <= at_base_q ? ST_READ : ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_kind_q             <= srr_pkg::KIND_DELIVER;
            m_seq_q              <= '0;
            m_data_q             <= ram_rdata;
            m_last_q             <= !more;
            filled_q[run_slot_q] <= 1'b0;
            run_slot_q           <= next_slot;
            run_cnt_q            <= run_cnt_inc;
            if (more) begin
              state_q <= ST_READ;
            end else begin
              base_q      <= base_new[srr_pkg::SEQ_W-1:0];
              base_slot_q <= base_new[srr_pkg::SEQ_W] ? wrap_slot : next_slot;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {2'b00, m_data_q, m_seq_q, m_seq_q};

  // configuration port
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == srr_pkg::REG_WINDOW)
                     ? srr_pkg::APB_DATA_W'(window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= srr_pkg::WINDOW_RESET;
    end else if (cfg_write && (paddr[2] == srr_pkg::REG_WINDOW)) begin
      window_q <= pwdata[srr_pkg::WIN_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_deliver_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> filled_q[run_slot_q])
    else $error("delivery from an empty slot");

  a_deliver_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> !filled_q[$past(run_slot_q)])
    else $error("slot flag not cleared after delivery");

  a_run_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ((srr_pkg::RUN_W+1)'(run_cnt_q) < (srr_pkg::RUN_W+1)'(win)))
    else $error("delivery run longer than the window");

  a_base_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((SW+1)'(base_slot_q) < (SW+1)'(D)) && ((SW+1)'(run_slot_q) < (SW+1)'(D)))
    else $error("slot index out of buffer range");
`endif

endmodule

### verif/tb_selective_repeat_receiver.sv
// Self-checking testbench for selective_repeat_receiver: packets go in on s_axis, acks and
// in-order deliveries are checked on m_axis against a predictor of the receive window.
// Depends on srr_pkg and the selective_repeat_receiver RTL.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver;
  import srr_pkg::*;

  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam int unsigned CYCLE_LIMIT   = 1_200_000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_LIMIT   = 200_000;

  typedef enum {BASE_SKIP, BASE_ANY, BASE_LAST} base_plan_e;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [31:0]       ack;
    logic [31:0]       csum;
    logic [63:0]       pay_lo;
    logic [63:0]       pay_mid;
    logic [31:0]       pay_hi;
  } arq_pkt_t;

  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  ack_seq;
    logic [SEQ_W-1:0]  ack_check;
    logic [63:0]       data_lo;
    logic [63:0]       data_mid;
    logic [31:0]       data_hi;
    logic              last_run;
  } arq_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // receiver state as predicted
  logic [SEQ_W-1:0]  rx_base = BASE_RESET;
  logic [WIN_W-1:0]  rx_win = WINDOW_RESET;
  logic              slot_full [BUFFER_DEPTH];
  logic [63:0]       slot_lo   [BUFFER_DEPTH];
  logic [63:0]       slot_mid  [BUFFER_DEPTH];
  logic [31:0]       slot_hi   [BUFFER_DEPTH];

  arq_pkt_t    tx_pkt_q[$];
  arq_word_t   due_word_q[$];
  arq_pkt_t    in_flight;

  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned word_cnt = 0;
  int unsigned deliver_cnt = 0;
  int unsigned longest_run = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;

  selective_repeat_receiver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] pkt_sum(arq_pkt_t p);
    logic [31:0]  acc;
    logic [159:0] pl;
    int           i;
    pl  = {p.pay_hi, p.pay_mid, p.pay_lo};
    acc = {1'b0, p.seq} + p.ack;
    for (i = 0; i < 20; i++) acc += {{24{pl[8*i+7]}}, pl[8*i +: 8]};
    return acc;
  endfunction

  // ack first, then the in-order run starting at the base
  function automatic void rx_predict(arq_pkt_t p);
    arq_word_t   w;
    int unsigned win, k, s, slot;
    win = (int'(rx_win) > WIN_MAX) ? WIN_MAX : rx_win;
    if (pkt_sum(p) != p.csum) return;
    if ({1'b0, p.seq} + 32'd1 > {1'b0, rx_base} + win) return;
    w = '0;
    w.kind      = KIND_ACK;
    w.ack_seq   = p.seq;
    w.ack_check = p.seq;
    due_word_q.insert(due_word_q.size(), w);
    if (p.seq >= rx_base) begin
      slot = p.seq % BUFFER_DEPTH;
      slot_lo[slot]   = p.pay_lo;
      slot_mid[slot]  = p.pay_mid;
      slot_hi[slot]   = p.pay_hi;
      slot_full[slot] = 1'b1;
      if (p.seq == rx_base) begin
        k = 0;
        s = rx_base % BUFFER_DEPTH;
        while (k < win && slot_full[s]) begin
          w = '0;
          w.kind     = KIND_DELIVER;
          w.data_lo  = slot_lo[s];
          w.data_mid = slot_mid[s];
          w.data_hi  = slot_hi[s];
          due_word_q.insert(due_word_q.size(), w);
          slot_full[s] = 1'b0;
          k++;
          s = ({1'b0, rx_base} + k) % BUFFER_DEPTH;
        end
        deliver_cnt += k;
        if (k > longest_run) longest_run = k;
        rx_base = SEQ_W'({1'b0, rx_base} + k);
      end
    end
    due_word_q[due_word_q.size()-1].last_run = 1'b1;
  endfunction

  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // packet source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rx_predict(in_flight);
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tx_pkt_q.size() != 0) begin
          in_flight = tx_pkt_q[0];
          tx_pkt_q.delete(0);
          s_axis_tdata  <= {1'b0, in_flight.pay_hi, in_flight.pay_mid, in_flight.pay_lo,
                            in_flight.csum, in_flight.ack, in_flight.seq};
          s_axis_tvalid <= 1'b1;
          src_gap       <= pick_gap(src_idle);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long sink hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_word(arq_word_t got);
    arq_word_t want;
    if (due_word_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected word: kind=%0d seq=%h chk=%h lo=%h mid=%h hi=%h last=%0d",
                 got.kind, got.ack_seq, got.ack_check, got.data_lo, got.data_mid,
                 got.data_hi, got.last_run);
    end else begin
      want = due_word_q[0];
      due_word_q.delete(0);
      if (want !== got) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("mismatch at word %0d", word_cnt);
          $display("  want kind=%0d seq=%h chk=%h lo=%h mid=%h hi=%h last=%0d",
                   want.kind, want.ack_seq, want.ack_check, want.data_lo, want.data_mid,
                   want.data_hi, want.last_run);
          $display("  got  kind=%0d seq=%h chk=%h lo=%h mid=%h hi=%h last=%0d",
                   got.kind, got.ack_seq, got.ack_check, got.data_lo, got.data_mid,
                   got.data_hi, got.last_run);
        end
      end
    end
  endtask

  // result sink
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_word({m_axis_tuser, m_axis_tdata[30:0], m_axis_tdata[61:31],
                    m_axis_tdata[125:62], m_axis_tdata[189:126], m_axis_tdata[221:190],
                    m_axis_tlast});
        word_cnt++;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap      <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) sink_gap <= pick_gap(sink_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("selective_repeat_receiver verification failed");
      $finish;
    end
  end

  task automatic queue_pkt(input logic [SEQ_W-1:0] seq, input logic [31:0] ack,
                           input logic [63:0] lo, input logic [63:0] mid,
                           input logic [31:0] hi, input bit corrupt);
    arq_pkt_t p;
    p.seq     = seq;
    p.ack     = ack;
    p.pay_lo  = lo;
    p.pay_mid = mid;
    p.pay_hi  = hi;
    p.csum    = pkt_sum(p) ^ (corrupt ? (32'd1 << $urandom_range(0, 31)) : 32'd0);
    tx_pkt_q.insert(tx_pkt_q.size(), p);
    queued_cnt++;
  endtask

  task automatic send_rand(input logic [SEQ_W-1:0] seq, input bit corrupt);
    queue_pkt(seq, $urandom, rnd64(), rnd64(), $urandom, corrupt);
  endtask

  task automatic wait_sent();
    while (accepted_cnt != queued_cnt) @(posedge clk_i);
  endtask

  // block idle: all words out, plus margin for a packet that makes no word
  task automatic settle();
    while (accepted_cnt != queued_cnt || due_word_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_WINDOW) rx_win = data[WIN_W-1:0];
  endtask

  // up to one window's worth of packets, shuffled, with retransmits and stray packets mixed in
  task automatic run_burst(input int unsigned n, input base_plan_e plan);
    int unsigned offs[$];
    int unsigned win, m, i, j, t, r;
    logic [SEQ_W-1:0] b, seq;
    win = (int'(rx_win) > WIN_MAX) ? WIN_MAX : rx_win;
    b   = rx_base;
    m   = (n < win) ? n : win;
    for (i = 1; i < m; i++) offs.insert(offs.size(), i);
    for (i = 0; i < offs.size(); i++) begin
      j = $urandom_range(i, offs.size() - 1);
      t = offs[i];
      offs[i] = offs[j];
      offs[j] = t;
    end
    if (plan == BASE_LAST) offs.insert(offs.size(), 0);
    else if (plan == BASE_ANY) offs.insert($urandom_range(0, offs.size()), 0);
    foreach (offs[i]) begin
      seq = b + SEQ_W'(offs[i]);
      r = $urandom_range(0, 99);
      if (r < 8) send_rand(seq, 1'b1);
      else if (r < 13) send_rand(seq, 1'b0);
      else if (r < 18) send_rand(SEQ_W'($urandom_range(b - 1, (b > 20) ? b - 20 : 0)), 1'b0);
      else if (r < 20) send_rand(SEQ_W'($urandom), 1'b0);
      else if (r < 23) send_rand(b + SEQ_W'(win + $urandom_range(0, 40)), 1'b0);
      send_rand(seq, 1'b0);
    end
    wait_sent();
  endtask

  initial begin
    int unsigned wins[7];
    int unsigned ph, start_cnt, drain, r;
    logic [SEQ_W-1:0] b;
    base_plan_e plan;
    wins = '{8, 63, 1, 32, 5, 17, 0};
    foreach (slot_full[i]) slot_full[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset window of 8, base at 1
    queue_pkt(31'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b0);
    queue_pkt(31'd1, 32'h7FFF_FFFF, '1, '1, '1, 1'b0);
    queue_pkt(31'h7FFF_FFFF, 32'h8000_0000, rnd64(), rnd64(), $urandom, 1'b0);
    send_rand(31'd2, 1'b1);
    queue_pkt(31'd4, 32'h8000_0000, {8{8'h80}}, {8{8'h7F}}, {4{8'h80}}, 1'b0);
    send_rand(31'd3, 1'b0);
    queue_pkt(31'd4, 32'h8000_0000, {8{8'h80}}, {8{8'h7F}}, {4{8'h80}}, 1'b0);
    send_rand(31'd9, 1'b0);
    send_rand(31'd10, 1'b0);
    send_rand(31'd2, 1'b0);
    send_rand(31'd1, 1'b0);
    settle();
    // unmapped register: window must stay at 8
    apb_write(ADDR_UNUSED, 32'h3F);
    b = rx_base;
    send_rand(b + 31'd8, 1'b0);
    send_rand(b + 31'd7, 1'b0);
    send_rand(b, 1'b0);
    settle();
    apb_write(ADDR_WINDOW, 32'd0);
    b = rx_base;
    send_rand(b, 1'b0);
    send_rand(b - 31'd1, 1'b0);
    send_rand(31'd0, 1'b0);
    settle();
    apb_write(ADDR_WINDOW, 32'd1);
    b = rx_base;
    send_rand(b + 31'd1, 1'b0);
    send_rand(b, 1'b0);
    send_rand(b + 31'd1, 1'b0);
    settle();
    apb_write(ADDR_WINDOW, 32'hFFFF_FFFF);
    b = rx_base;
    send_rand(b + 31'd32, 1'b0);
    send_rand(b + 31'd31, 1'b0);
    send_rand(b, 1'b0);

    for (ph = 0; ph < 7; ph++) begin
      settle();
      apb_write(ADDR_WINDOW, (ph == 6) ? $urandom_range(2, 31) : wins[ph]);
      src_idle  = (ph % 3) != 1;
      sink_idle = (ph % 3) != 2;
      start_cnt = queued_cnt;
      if (wins[ph] == 63) begin
        // sink held off as a full window starts to go in, base last: longest run
        @(posedge clk_i);
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
        run_burst(32, BASE_LAST);
      end
      while (queued_cnt - start_cnt < 16) begin
        r = $urandom_range(0, 99);
        plan = (r < 20) ? BASE_SKIP : (r < 50) ? BASE_ANY : BASE_LAST;
        run_burst($urandom_range(1, 12), plan);
      end
    end

    drain = 0;
    while ((accepted_cnt != queued_cnt || due_word_q.size() != 0) && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_word_q.size() != 0) begin
      $display("%0d expected words never arrived", due_word_q.size());
      mismatch_cnt += due_word_q.size();
    end
    $display("run: %0d packets in, %0d words out, %0d payloads delivered, longest run %0d",
             accepted_cnt, word_cnt, deliver_cnt, longest_run);
    $display("windows 0, 1, 8, 32 and saturated 63 plus mid values; %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("selective_repeat_receiver verification clean");
    end else begin
      $display("selective_repeat_receiver verification failed");
    end
    $finish;
  end

endmodule
